@@ hw/rtl/ivs_pkg.sv @@
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types and codes for the indexed vector store: request actions,
// result status codes and the control bundles between the sequencer and
// the chain of storage cells.
// ----------------------------------------------------------------------------
package ivs_pkg;

	localparam int unsigned WORD_W = 32;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_ERASE  = 3'd2,
		ACT_READ   = 3'd3,
		ACT_WRITE  = 3'd4,
		ACT_COUNT  = 3'd5,
		ACT_CLEAR  = 3'd6
	} ivs_action_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} ivs_status_t;

	// Sequencer to chain: rotate enable and the word entering the tail cell.
	typedef struct packed {
		logic                     shift;
		logic signed [WORD_W-1:0] tail;
	} ivs_feed_t;

	// Chain to sequencer: the two cells nearest the head.
	typedef struct packed {
		logic signed [WORD_W-1:0] head;
		logic signed [WORD_W-1:0] next;
	} ivs_taps_t;

endpackage

@@ hw/rtl/indexed_vector_store_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_vector_store_unit
// Ordered store of signed words with a fill count: append, insert, erase,
// read, write, count matches and clear, held in a rotating ring of cells.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   request | req_valid/req_stall  | action, position, word_in
//   result  | rsp_valid/rsp_stall  | word_out, match_count, fill_level, status
//
// Any action that touches stored data turns the ring of DEPTH cells once,
// one entry past the head per cycle, and no new request is taken until the
// result has been loaded into the output register. Rejected actions, clear
// and the unused code skip the walk and go straight to the done state.
// Reset clears the fill count and the handshake state; cell contents stay
// undefined until written. A stalled result holds in the output register
// while the next request is taken and worked on.
// ----------------------------------------------------------------------------
module indexed_vector_store_unit #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned IDX_W = $clog2(DEPTH),
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [2:0]                        action,
	input  logic [IDX_W-1:0]                  position,
	input  logic signed [ivs_pkg::WORD_W-1:0] word_in,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [ivs_pkg::WORD_W-1:0] word_out,
	output logic [CNT_W-1:0]                  match_count,
	output logic [CNT_W-1:0]                  fill_level,
	output logic [1:0]                        status
);
	import ivs_pkg::*;

	ivs_feed_t feed;
	ivs_taps_t taps;

	ivs_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.position    (position),
		.word_in     (word_in),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.word_out    (word_out),
		.match_count (match_count),
		.fill_level  (fill_level),
		.status      (status),
		.feed        (feed),
		.taps        (taps)
	);

	ivs_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk  (clk),
		.feed (feed),
		.taps (taps)
	);

endmodule

@@ hw/rtl/ivs_cell.sv @@
// ----------------------------------------------------------------------------
// ivs_cell
// One storage cell of the ring: holds a single word and takes its
// neighbor's word whenever the ring rotates.
// ----------------------------------------------------------------------------
module ivs_cell (
	input  logic                              clk,
	input  logic                              shift,
	input  logic signed [ivs_pkg::WORD_W-1:0] d,
	output logic signed [ivs_pkg::WORD_W-1:0] q
);
	import ivs_pkg::*;

	logic signed [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

@@ hw/rtl/ivs_chain.sv @@
// ----------------------------------------------------------------------------
// ivs_chain
// Row of DEPTH cells. On each rotate every cell takes the word of the cell
// above it; the top cell takes the feed word. Cell 0 is the read head.
// ----------------------------------------------------------------------------
module ivs_chain #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                clk,
	input  ivs_pkg::ivs_feed_t  feed,
	output ivs_pkg::ivs_taps_t  taps
);
	import ivs_pkg::*;

	logic signed [WORD_W-1:0] cell_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] cell_d;

		if (i == DEPTH - 1) begin : g_top
			assign cell_d = feed.tail;
		end else begin : g_mid
			assign cell_d = cell_q[i+1];
		end

		ivs_cell u_cell (
			.clk   (clk),
			.shift (feed.shift),
			.d     (cell_d),
			.q     (cell_q[i])
		);
	end

	assign taps.head = cell_q[0];
	assign taps.next = cell_q[1];

endmodule

@@ hw/rtl/ivs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ivs_ctrl
// Sequencer for the store: decodes a transaction, checks it against the
// fill count, walks the ring once for actions that reach stored data, and
// returns the result through an output register.
// ----------------------------------------------------------------------------
module ivs_ctrl #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned IDX_W = $clog2(DEPTH),
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [2:0]                        action,
	input  logic [IDX_W-1:0]                  position,
	input  logic signed [ivs_pkg::WORD_W-1:0] word_in,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [ivs_pkg::WORD_W-1:0] word_out,
	output logic [CNT_W-1:0]                  match_count,
	output logic [CNT_W-1:0]                  fill_level,
	output logic [1:0]                        status,
	output ivs_pkg::ivs_feed_t                feed,
	input  ivs_pkg::ivs_taps_t                taps
);
	import ivs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                   state_q;
	ivs_action_t              op_q;
	logic [IDX_W-1:0]         pos_q;
	logic signed [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]         fill_q;
	ivs_status_t              status_q;
	logic [IDX_W-1:0]         k_q;
	logic signed [WORD_W-1:0] carry_q;
	logic signed [WORD_W-1:0] rd_q;
	logic [CNT_W-1:0]         match_q;

	logic                     rsp_valid_q;
	logic signed [WORD_W-1:0] rsp_word_q;
	logic [CNT_W-1:0]         rsp_match_q;
	logic [CNT_W-1:0]         rsp_fill_q;
	ivs_status_t              rsp_status_q;

	logic             accept;
	logic             rsp_free;
	logic             rsp_load;
	ivs_action_t      act_in;
	logic [CNT_W-1:0] pos_ext;
	logic             is_full;
	logic             walk_go;
	ivs_status_t      stat_nx;
	logic [CNT_W-1:0] fill_nx;
	logic [IDX_W-1:0] idx_nx;
	logic             at_pos;
	logic             past_pos;
	logic             last_k;
	logic             hit;
	logic             grab;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == ST_DONE) && rsp_free;
	assign act_in    = ivs_action_t'(action);
	assign pos_ext   = CNT_W'(position);
	assign is_full   = (fill_q == CNT_W'(DEPTH));

	// Range and capacity checks happen up front; the walk only moves, reads and counts data.
	always_comb begin
		walk_go = 1'b0;
		stat_nx = STATUS_OK;
		fill_nx = fill_q;
		idx_nx  = position;
		unique case (act_in) inside
			ACT_APPEND: begin
				if (is_full) begin
					stat_nx = STATUS_FULL;
				end else begin
					walk_go = 1'b1;
					idx_nx  = IDX_W'(fill_q);
					fill_nx = fill_q + CNT_W'(1);
				end
			end
			ACT_INSERT: begin
				if (pos_ext > fill_q) begin
					stat_nx = STATUS_RANGE;
				end else if (is_full) begin
					stat_nx = STATUS_FULL;
				end else begin
					walk_go = 1'b1;
					fill_nx = fill_q + CNT_W'(1);
				end
			end
			ACT_ERASE: begin
				if (pos_ext >= fill_q) begin
					stat_nx = STATUS_RANGE;
				end else begin
					walk_go = 1'b1;
					fill_nx = fill_q - CNT_W'(1);
				end
			end
			ACT_READ, ACT_WRITE: begin
				if (pos_ext >= fill_q) begin
					stat_nx = STATUS_RANGE;
				end else begin
					walk_go = 1'b1;
				end
			end
			ACT_COUNT: begin
				walk_go = 1'b1;
			end
			ACT_CLEAR: begin
				fill_nx = '0;
			end
			default: begin
			end
		endcase
	end

	assign at_pos   = (k_q == pos_q);
	assign past_pos = (k_q > pos_q);
	assign last_k   = (k_q == IDX_W'(DEPTH - 1));
	assign hit      = (op_q == ACT_COUNT) && (CNT_W'(k_q) < fill_q) && (taps.head == word_q);
	assign grab     = (op_q == ACT_READ) && at_pos;

	// Entry k passes the head while the walk counter is k; what enters the tail
	// at that step lands back in slot k once the ring has turned all the way.
	always_comb begin
		feed.shift = (state_q == ST_WALK);
		feed.tail  = taps.head;
		case (op_q) inside
			ACT_INSERT: begin
				if (at_pos) begin
					feed.tail = word_q;
				end else if (past_pos) begin
					feed.tail = carry_q;
				end
			end
			ACT_ERASE: begin
				if (at_pos || past_pos) begin
					feed.tail = taps.next;
				end
			end
			ACT_APPEND, ACT_WRITE: begin
				if (at_pos) begin
					feed.tail = word_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= ACT_APPEND;
			pos_q        <= '0;
			word_q       <= '0;
			fill_q       <= '0;
			status_q     <= STATUS_OK;
			k_q          <= '0;
			carry_q      <= '0;
			rd_q         <= '0;
			match_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_word_q   <= '0;
			rsp_match_q  <= '0;
			rsp_fill_q   <= '0;
			rsp_status_q <= STATUS_OK;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= act_in;
						pos_q    <= idx_nx;
						word_q   <= word_in;
						fill_q   <= fill_nx;
						status_q <= stat_nx;
						k_q      <= '0;
						rd_q     <= '0;
						match_q  <= '0;
						state_q  <= walk_go ? ST_WALK : ST_DONE;
					end
				end
				ST_WALK: begin
					carry_q <= taps.head;
					k_q     <= k_q + IDX_W'(1);
					if (hit) begin
						match_q <= match_q + CNT_W'(1);
					end
					if (grab) begin
						rd_q <= taps.head;
					end
					if (last_k) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold the result until the output register is free.
					if (rsp_load) begin
						rsp_word_q   <= rd_q;
						rsp_match_q  <= match_q;
						rsp_fill_q   <= fill_q;
						rsp_status_q <= status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign word_out    = rsp_word_q;
	assign match_count = rsp_match_q;
	assign fill_level  = rsp_fill_q;
	assign status      = rsp_status_q;

endmodule

@@ hw/rtl/ivs_checker.sv @@
// ----------------------------------------------------------------------------
// ivs_checker
// Port-level checks for the indexed vector store, bound to the top level.
// ----------------------------------------------------------------------------
module ivs_checker #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic signed [ivs_pkg::WORD_W-1:0] word_out,
	input logic [CNT_W-1:0]                  match_count,
	input logic [CNT_W-1:0]                  fill_level,
	input logic [1:0]                        status
);
	import ivs_pkg::*;

	// One transaction at a time: a taken request makes the block busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not stalled after a transaction");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fill_level <= CNT_W'(DEPTH))
		else $error("fill level beyond capacity");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STATUS_FULL |-> fill_level == CNT_W'(DEPTH))
		else $error("full status with room left");

	// A read word and a match count never come from the same transaction.
	a_one_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && match_count != '0 |-> word_out == '0)
		else $error("read word and match count both set");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(word_out) &&
		$stable(match_count) && $stable(fill_level) && $stable(status))
		else $error("stalled result changed");

endmodule

bind indexed_vector_store_unit ivs_checker #(
	.DEPTH (DEPTH)
) u_ivs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.word_out    (word_out),
	.match_count (match_count),
	.fill_level  (fill_level),
	.status      (status)
);
